[hw/rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg: shared definitions for the sorted list engine
// Command and status codes, data widths and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 16;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_MIN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_MAX  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_VAL  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic eval;     // capture compare flags against the operand
    logic ins;      // open a gap at the insert point and drop the operand in
    logic shl_all;  // every cell takes its right neighbor (remove the head)
    logic shl_ge;   // cells at or past the match take their right neighbor
  } cell_op_t;

endpackage

`default_nettype wire

[hw/rtl/sle_in_if.sv]
// ----------------------------------------------------------------------------
// sle_in_if: command channel of the sorted list engine
// Valid/ready channel carrying one command and its operand.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_in_if;
  logic                             valid;
  logic                             ready;
  logic [sle_pkg::CMD_W-1:0]        cmd;
  logic signed [sle_pkg::DATA_W-1:0] operand_value;

  modport source (output valid, output cmd, output operand_value, input ready);
  modport sink   (input valid, input cmd, input operand_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/sle_out_if.sv]
// ----------------------------------------------------------------------------
// sle_out_if: result channel of the sorted list engine
// Valid/ready channel carrying status, removed value and entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_out_if #(
  parameter int CNT_W = $clog2(sle_pkg::DEPTH_DEFAULT + 1)
);
  logic                              valid;
  logic                              ready;
  logic [sle_pkg::STATUS_W-1:0]      status;
  logic signed [sle_pkg::DATA_W-1:0] removed_value;
  logic [CNT_W-1:0]                  entry_count;

  modport source (output valid, output status, output removed_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input entry_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/sle_cell.sv]
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted chain
// Holds one entry, compares it with the operand and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire sle_pkg::cell_op_t           op,
  input  wire signed [sle_pkg::DATA_W-1:0] operand,
  input  wire [CNT_W-1:0]                  count,
  input  wire signed [sle_pkg::DATA_W-1:0] left_entry,
  input  wire                              left_ge,
  input  wire signed [sle_pkg::DATA_W-1:0] right_entry,
  output logic signed [sle_pkg::DATA_W-1:0] entry,
  output logic                             ge,
  output logic                             hit,
  output logic signed [sle_pkg::DATA_W-1:0] last_entry
);

  logic signed [sle_pkg::DATA_W-1:0] entry_r, entry_nxt;
  logic ge_r, ge_nxt;
  logic eq_r, eq_nxt;
  logic last_r, last_nxt;
  logic occupied;

  assign occupied = CNT_W'(IDX) < count;

  // An empty slot counts as greater-or-equal, so the first empty slot is the
  // insert point when every stored entry is smaller than the operand.
  always_comb begin
    ge_nxt   = ge_r;
    eq_nxt   = eq_r;
    last_nxt = last_r;
    if (op.eval) begin
      ge_nxt   = !occupied || !(entry_r < operand);
      eq_nxt   = occupied && (entry_r == operand);
      last_nxt = (CNT_W'(IDX + 1) == count);
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (op.ins && ge_r) begin
      entry_nxt = left_ge ? left_entry : operand;
    end else if (op.shl_all || (op.shl_ge && ge_r)) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r   <= 1'b0;
      eq_r   <= 1'b0;
      last_r <= 1'b0;
    end else begin
      ge_r   <= ge_nxt;
      eq_r   <= eq_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry      = entry_r;
  assign ge         = ge_r;
  assign hit        = ge_r && !left_ge && eq_r;
  assign last_entry = last_r ? entry_r : '0;

endmodule

`default_nettype wire

[hw/rtl/sorted_list_engine.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine: bounded sorted multiset of signed 32-bit values
// A chain of DEPTH cells keeps the entries in ascending order in slots
// 0 .. count-1; a small controller sequences each command through the chain.
// ----------------------------------------------------------------------------
// Each command transaction runs in order: the accept edge latches the
// command, in the evaluate phase every cell compares its entry with the
// operand in parallel and registers the result in its compare flags, and in
// the update phase the chain shifts and the result register loads. One
// command is in the chain at a time, so a new command is taken only once the
// previous one has left the update phase. A finished result waits in its own
// register, so the next command is accepted while the previous result has not
// yet been taken; its update stage then waits for the result register to
// drain. Insert puts the value in front of the first entry that is greater
// than or equal to it, delete-min and delete-max return the end entries,
// search reports a match, and delete-value removes one equal entry. Status
// reports an empty store, a missing value or an insert into a full store,
// which is dropped. Unused command codes leave the store alone and report ok.
// The store needs no clearing after reset: only slots below the entry count
// are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine #(
  parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
  input  wire        clk,
  input  wire        rst_n,
  sle_in_if.sink     in_ch,
  sle_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_EVAL = 2'd1;
  localparam logic [1:0] PH_UPD  = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [sle_pkg::CMD_W-1:0] cmd_r;
  logic signed [sle_pkg::DATA_W-1:0] operand_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [sle_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic signed [sle_pkg::DATA_W-1:0] removed_r, removed_nxt;

  logic accept;
  logic upd_go;
  logic full;
  logic empty;
  logic found;
  logic signed [sle_pkg::DATA_W-1:0] max_entry;
  sle_pkg::cell_op_t op;

  logic signed [sle_pkg::DATA_W-1:0] entry_a [DEPTH];
  logic signed [sle_pkg::DATA_W-1:0] last_a  [DEPTH];
  logic [DEPTH-1:0] ge_vec;
  logic [DEPTH-1:0] hit_vec;

  assign in_ch.ready = (phase_r == PH_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // The update stage only runs once the result register is free or draining.
  assign upd_go = (phase_r == PH_UPD) && (!out_valid_r || out_ch.ready);

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // The first greater-or-equal cell is the only place an equal entry can
  // first appear, so at most one cell raises its hit flag.
  assign found = |hit_vec;

  // Of a non-empty store exactly one occupied cell marks itself as last;
  // all others give zero, so an OR over the chain picks the largest entry.
  always_comb begin
    max_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      max_entry = max_entry | last_a[i];
    end
  end

  always_comb begin
    op.eval    = (phase_r == PH_EVAL);
    op.ins     = upd_go && (cmd_r == sle_pkg::CMD_INSERT) && !full;
    op.shl_all = upd_go && (cmd_r == sle_pkg::CMD_DEL_MIN) && !empty;
    op.shl_ge  = upd_go && (cmd_r == sle_pkg::CMD_DEL_VAL) && found;
  end

  generate
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [sle_pkg::DATA_W-1:0] left_e;
      logic signed [sle_pkg::DATA_W-1:0] right_e;
      logic                              left_g;

      if (g == 0) begin : g_head
        assign left_e = entry_a[g];
        assign left_g = 1'b0;
      end else begin : g_body
        assign left_e = entry_a[g-1];
        assign left_g = ge_vec[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
        assign right_e = entry_a[g];
      end else begin : g_mid
        assign right_e = entry_a[g+1];
      end

      sle_cell #(
        .CNT_W (CNT_W),
        .IDX   (g)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .operand     (operand_r),
        .count       (count_r),
        .left_entry  (left_e),
        .left_ge     (left_g),
        .right_entry (right_e),
        .entry       (entry_a[g]),
        .ge          (ge_vec[g]),
        .hit         (hit_vec[g]),
        .last_entry  (last_a[g])
      );
    end
  endgenerate

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          phase_nxt = PH_EVAL;
        end
      end
      PH_EVAL: begin
        phase_nxt = PH_UPD;
      end
      PH_UPD: begin
        if (upd_go) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Result and entry count for the command in the update stage.
  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (upd_go) begin
      out_valid_nxt = 1'b1;
      status_nxt    = sle_pkg::ST_OK;
      removed_nxt   = '0;
      case (cmd_r)
        sle_pkg::CMD_INSERT: begin
          if (full) begin
            status_nxt = sle_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        sle_pkg::CMD_DEL_MIN: begin
          if (empty) begin
            status_nxt = sle_pkg::ST_EMPTY;
          end else begin
            removed_nxt = entry_a[0];
            count_nxt   = count_r - CNT_W'(1);
          end
        end
        sle_pkg::CMD_DEL_MAX: begin
          if (empty) begin
            status_nxt = sle_pkg::ST_EMPTY;
          end else begin
            removed_nxt = max_entry;
            count_nxt   = count_r - CNT_W'(1);
          end
        end
        sle_pkg::CMD_SEARCH, sle_pkg::CMD_DEL_VAL: begin
          if (empty) begin
            status_nxt = sle_pkg::ST_EMPTY;
          end else if (!found) begin
            status_nxt = sle_pkg::ST_NOTFOUND;
          end else if (cmd_r == sle_pkg::CMD_DEL_VAL) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = sle_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_ch.cmd;
      operand_r <= in_ch.operand_value;
    end
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  // The entry count only moves in the update stage, which waits for the
  // result register to drain, so it always matches the pending result.
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.entry_count   = count_r;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the sorted list engine
// Drives command transactions over the valid/ready input channel, keeps a
// shadow copy of the sorted store to predict every result, and compares each
// result transaction field by field. A short directed table comes first, then
// random traffic in fill, drain and mixed stretches under varying idle and
// stall pressure on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STORE_DEPTH = sle_pkg::DEPTH_DEFAULT;
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int RANDOM_ITEMS = 1600;
  localparam int SETTLE_CYCLES = 20;
  // The receiver holds off once for this many cycles, after this many results.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 60;

  // Command codes the block does not use; they must leave the store alone.
  localparam logic [sle_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [sle_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [sle_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [sle_pkg::STATUS_W-1:0]      status;
    logic signed [sle_pkg::DATA_W-1:0] removed_value;
    logic [COUNT_W-1:0]                entry_count;
  } list_result_t;

  typedef struct packed {
    logic [sle_pkg::CMD_W-1:0]         cmd;
    logic signed [sle_pkg::DATA_W-1:0] operand;
    logic                              typed;   // result below is typed in by hand
    list_result_t                      result;
  } directed_row_t;

  typedef enum int {TRAFFIC_FILL, TRAFFIC_DRAIN, TRAFFIC_MIXED} traffic_mode_t;

  logic clk;
  logic rst_n;

  sle_in_if  in_ch ();
  sle_out_if #(.CNT_W(COUNT_W)) out_ch ();

  sorted_list_engine #(
    .DEPTH (STORE_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow of the store, kept in ascending signed order, and the results that
  // accepted commands have yet to produce, oldest first.
  logic signed [sle_pkg::DATA_W-1:0] shadow_entries[$];
  list_result_t                      pending_results[$];
  directed_row_t                     directed_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count = 0;
  int results_seen = 0;

  // Operands that recur often, so that searches, deletes and duplicate
  // inserts hit stored entries. The two extremes of the range are included.
  logic signed [sle_pkg::DATA_W-1:0] common_operands[8] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1,
    32'sd1, 32'sd7, -32'sd100, 32'sh4000_0000
  };

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Applies one command to the shadow store and returns the result that the
  // block must produce for it.
  function automatic list_result_t apply_command(
      input logic [sle_pkg::CMD_W-1:0] cmd,
      input logic signed [sle_pkg::DATA_W-1:0] operand);
    list_result_t res;
    int pos;
    res = '0;
    res.status = sle_pkg::ST_OK;
    case (cmd)
      sle_pkg::CMD_INSERT: begin
        if (shadow_entries.size() >= STORE_DEPTH) begin
          res.status = sle_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_entries.size() && shadow_entries[pos] < operand) pos++;
          shadow_entries.insert(pos, operand);
        end
      end
      sle_pkg::CMD_DEL_MIN: begin
        if (shadow_entries.size() == 0) begin
          res.status = sle_pkg::ST_EMPTY;
        end else begin
          res.removed_value = shadow_entries.pop_front();
        end
      end
      sle_pkg::CMD_DEL_MAX: begin
        if (shadow_entries.size() == 0) begin
          res.status = sle_pkg::ST_EMPTY;
        end else begin
          res.removed_value = shadow_entries.pop_back();
        end
      end
      sle_pkg::CMD_SEARCH, sle_pkg::CMD_DEL_VAL: begin
        if (shadow_entries.size() == 0) begin
          res.status = sle_pkg::ST_EMPTY;
        end else begin
          res.status = sle_pkg::ST_NOTFOUND;
          for (pos = 0; pos < shadow_entries.size(); pos++) begin
            if (shadow_entries[pos] == operand) begin
              res.status = sle_pkg::ST_OK;
              // Only the first of several equal entries is removed.
              if (cmd == sle_pkg::CMD_DEL_VAL) shadow_entries.delete(pos);
              break;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.entry_count = COUNT_W'(shadow_entries.size());
    return res;
  endfunction

  // The share of inserts sets whether the store tends to fill up or drain.
  function automatic logic [sle_pkg::CMD_W-1:0] pick_command(input traffic_mode_t mode);
    int roll;
    int insert_share;
    roll = $urandom_range(99);
    case (mode)
      TRAFFIC_FILL:  insert_share = 65;
      TRAFFIC_DRAIN: insert_share = 15;
      default:       insert_share = 35;
    endcase
    if (roll < 2) begin
      case ($urandom_range(2))
        0:       return CMD_SPARE_5;
        1:       return CMD_SPARE_6;
        default: return CMD_SPARE_7;
      endcase
    end
    if (roll < 2 + insert_share) return sle_pkg::CMD_INSERT;
    case (roll % 4)
      0:       return sle_pkg::CMD_DEL_MIN;
      1:       return sle_pkg::CMD_DEL_MAX;
      2:       return sle_pkg::CMD_SEARCH;
      default: return sle_pkg::CMD_DEL_VAL;
    endcase
  endfunction

  // Searches and deletes often name a stored value; otherwise operands come
  // from the recurring set or from the whole 32-bit range.
  function automatic logic signed [sle_pkg::DATA_W-1:0] pick_operand(
      input logic [sle_pkg::CMD_W-1:0] cmd);
    int roll;
    roll = $urandom_range(99);
    if ((cmd == sle_pkg::CMD_SEARCH || cmd == sle_pkg::CMD_DEL_VAL) &&
        shadow_entries.size() != 0 && roll < 50) begin
      return shadow_entries[$urandom_range(shadow_entries.size() - 1)];
    end
    if (roll < 75) return common_operands[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic add_checked_row(input logic [sle_pkg::CMD_W-1:0] cmd,
                                 input logic signed [sle_pkg::DATA_W-1:0] operand,
                                 input logic [sle_pkg::STATUS_W-1:0] status,
                                 input logic signed [sle_pkg::DATA_W-1:0] removed,
                                 input int count);
    directed_row_t row;
    row.cmd = cmd;
    row.operand = operand;
    row.typed = 1'b1;
    row.result.status = status;
    row.result.removed_value = removed;
    row.result.entry_count = COUNT_W'(count);
    directed_rows.push_back(row);
  endtask

  task automatic add_predicted_row(input logic [sle_pkg::CMD_W-1:0] cmd,
                                   input logic signed [sle_pkg::DATA_W-1:0] operand);
    directed_row_t row;
    row = '0;
    row.cmd = cmd;
    row.operand = operand;
    directed_rows.push_back(row);
  endtask

  // Offers one command transaction, after an optional random idle gap, and
  // waits for the edge at which it is accepted. The shadow store is updated
  // at that edge. A typed-in expectation, where given, replaces the predicted
  // one in the queue; the shadow store still follows the command.
  task automatic send_command(input logic [sle_pkg::CMD_W-1:0] cmd,
                              input logic signed [sle_pkg::DATA_W-1:0] operand,
                              input logic typed,
                              input list_result_t typed_result);
    list_result_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.operand_value <= operand;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = apply_command(cmd, operand);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Result side: checks every accepted result against the oldest pending
  // expectation, and decides ready for the next cycle. Once, after a few
  // dozen results, ready stays low for a long stretch so that the block
  // backs up and stalls its input channel while commands keep coming.
  always @(posedge clk) begin : result_side
    list_result_t expected;
    int hold_left;
    bit hold_done;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction arrived with no command outstanding");
          error_count++;
        end else begin
          expected = pending_results.pop_front();
          if (out_ch.status !== expected.status) begin
            $error("status: expected %0d, actual %0d", expected.status, out_ch.status);
            error_count++;
          end
          if (out_ch.removed_value !== expected.removed_value) begin
            $error("removed_value: expected %0d, actual %0d",
                   expected.removed_value, out_ch.removed_value);
            error_count++;
          end
          if (out_ch.entry_count !== expected.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   expected.entry_count, out_ch.entry_count);
            error_count++;
          end
        end
        results_seen++;
      end
      if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    directed_row_t row;
    traffic_mode_t mode;
    logic [sle_pkg::CMD_W-1:0] cmd;
    int segment_left;
    int i;

    in_ch.valid         = 1'b0;
    in_ch.cmd           = sle_pkg::CMD_INSERT;
    in_ch.operand_value = '0;
    rst_n               = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;

    // Directed table. Every removal and search on an empty store reports
    // empty. The store is then filled to its bound with both extremes of the
    // range and some duplicates, an insert into the full store is dropped, and
    // the remaining commands start from the full store: a search hit, removal
    // of one of two equal entries, a delete that misses, both end removals and
    // two of the unused command codes.
    add_checked_row(sle_pkg::CMD_DEL_MIN, 32'sd0, sle_pkg::ST_EMPTY, 32'sd0, 0);
    add_checked_row(sle_pkg::CMD_DEL_MAX, 32'sd0, sle_pkg::ST_EMPTY, 32'sd0, 0);
    add_checked_row(sle_pkg::CMD_SEARCH,  32'sd5, sle_pkg::ST_EMPTY, 32'sd0, 0);
    add_checked_row(sle_pkg::CMD_DEL_VAL, 32'sd5, sle_pkg::ST_EMPTY, 32'sd0, 0);
    add_checked_row(sle_pkg::CMD_INSERT,  32'sh7FFF_FFFF, sle_pkg::ST_OK, 32'sd0, 1);
    add_checked_row(sle_pkg::CMD_INSERT,  32'sh8000_0000, sle_pkg::ST_OK, 32'sd0, 2);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'sd0);
    add_predicted_row(sle_pkg::CMD_INSERT, -32'sd1);
    add_predicted_row(sle_pkg::CMD_INSERT, -32'sd1);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'sd7);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'sd7);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'sd100);
    add_predicted_row(sle_pkg::CMD_INSERT, -32'sd100);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'sh4000_0000);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'shC000_0000);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'sd1);
    add_predicted_row(sle_pkg::CMD_INSERT, -32'sd2);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'sh7FFF_FFFE);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'sh8000_0001);
    add_predicted_row(sle_pkg::CMD_INSERT, 32'sd55);
    add_checked_row(sle_pkg::CMD_INSERT, 32'sd42, sle_pkg::ST_FULL, 32'sd0, 16);
    add_predicted_row(sle_pkg::CMD_SEARCH, -32'sd1);
    add_predicted_row(sle_pkg::CMD_DEL_VAL, -32'sd1);
    add_predicted_row(sle_pkg::CMD_SEARCH, -32'sd1);
    add_checked_row(sle_pkg::CMD_DEL_VAL, 32'sd99999, sle_pkg::ST_NOTFOUND, 32'sd0, 15);
    add_checked_row(sle_pkg::CMD_DEL_MIN, 32'sd0, sle_pkg::ST_OK, 32'sh8000_0000, 14);
    add_checked_row(sle_pkg::CMD_DEL_MAX, 32'sd0, sle_pkg::ST_OK, 32'sh7FFF_FFFF, 13);
    add_checked_row(CMD_SPARE_5, -32'sd1, sle_pkg::ST_OK, 32'sd0, 13);
    add_checked_row(CMD_SPARE_7, 32'sh7FFF_FFFF, sle_pkg::ST_OK, 32'sd0, 13);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_command(row.cmd, row.operand, row.typed, row.result);
    end

    // Random traffic in four pressure phases: none, sender idling, receiver
    // stalling, then light idling on both sides. Within each phase the
    // traffic alternates between stretches that fill the store, drain it and
    // mix the two, so that the full and empty cases keep recurring.
    segment_left = 0;
    mode = TRAFFIC_MIXED;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      case (i / (RANDOM_ITEMS / 4))
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct = 16;
          recv_stall_pct = 16;
        end
      endcase
      if (segment_left == 0) begin
        segment_left = $urandom_range(60, 20);
        case ($urandom_range(2))
          0:       mode = TRAFFIC_FILL;
          1:       mode = TRAFFIC_DRAIN;
          default: mode = TRAFFIC_MIXED;
        endcase
      end
      segment_left--;
      cmd = pick_command(mode);
      send_command(cmd, pick_operand(cmd), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    // Let every outstanding result drain, then watch a little longer for any
    // stray result transaction.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
